FILE: hdl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Holds default parameter values, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int CAPACITY_DEF     = 1024;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int MED_W            = 33;
   localparam int CNT_W            = 11;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RT_RD,      // replace-top: read children
      ST_RT_WAIT,
      ST_RT_CMP,     // replace-top: compare and swap
      ST_PU_RD,      // push: read parent
      ST_PU_WAIT,
      ST_PU_CMP,     // push: compare and swap
      ST_TOPS,       // tops settle
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture input sample
      logic decide;      // pick heaps and the value to push
      logic rt_start;    // write new top of source heap
      logic rt_read;     // issue child reads
      logic rt_step;     // compare children, swap or stop
      logic pu_start;    // write pushed value at the end
      logic pu_read;     // issue parent read
      logic pu_step;     // compare with parent, swap or stop
      logic finish;      // form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;        // store is full
      logic need_rt;     // replace-top is needed
      logic rt_done;     // sift-down finished
      logic pu_done;     // sift-up finished
   } sts_type;

endpackage

FILE: hdl/rmth_ctrl.sv
// ----------------------------------------------------------------------------
// rmth_ctrl: sequencer for one insertion
// Steps through reject check, optional sift-down of one heap, sift-up of the
// other, and result hand-off.
// ----------------------------------------------------------------------------
module rmth_ctrl
   import rmth_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.full) begin
               state_in = ST_TOPS;
            end else if (sts.need_rt) begin
               cmd.rt_start = 1'b1;
               state_in     = ST_RT_RD;
            end else begin
               cmd.pu_start = 1'b1;
               state_in     = ST_PU_RD;
            end
         end
         ST_RT_RD: begin
            if (sts.rt_done) begin
               cmd.pu_start = 1'b1;
               state_in     = ST_PU_RD;
            end else begin
               cmd.rt_read = 1'b1;
               state_in    = ST_RT_WAIT;
            end
         end
         ST_RT_WAIT: state_in = ST_RT_CMP;
         ST_RT_CMP: begin
            cmd.rt_step = 1'b1;
            state_in    = ST_RT_RD;
         end
         ST_PU_RD: begin
            if (sts.pu_done) begin
               state_in = ST_TOPS;
            end else begin
               cmd.pu_read = 1'b1;
               state_in    = ST_PU_WAIT;
            end
         end
         ST_PU_WAIT: state_in = ST_PU_CMP;
         ST_PU_CMP: begin
            cmd.pu_step = 1'b1;
            state_in    = ST_PU_RD;
         end
         ST_TOPS: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/rmth_datapath.sv
// ----------------------------------------------------------------------------
// rmth_datapath: two heap memories, fill counts and result registers
// Each heap is a one-write, two-read memory with registered read data.
// Heap tops are mirrored in registers for the median.
// ----------------------------------------------------------------------------
module rmth_datapath
   import rmth_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             sample,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   output logic signed [MED_W-1:0] median_doubled,
   output logic [CNT_W-1:0]        stored_count,
   output logic                    rejected
);

   localparam int HALF  = (CAPACITY + 1) / 2;
   localparam int AW    = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int FW    = $clog2(HALF + 1);
   localparam int TW    = $clog2(CAPACITY + 1);

   // memories: lo_mem = lower (max-heap), up_mem = upper (min-heap)
   logic signed [SAMPLE_WIDTH-1:0] lo_mem [HALF];
   logic signed [SAMPLE_WIDTH-1:0] up_mem [HALF];

   logic [FW-1:0] lo_fill_ff, up_fill_ff;
   logic          odd_ff;
   logic signed [SAMPLE_WIDTH-1:0] lo_top_ff, up_top_ff;
   logic signed [SAMPLE_WIDTH-1:0] v_ff;      // value being sifted
   logic signed [SAMPLE_WIDTH-1:0] push_ff;   // value to push
   logic          rt_max_ff;                   // sift-down heap is lower
   logic          pu_max_ff;                   // sift-up heap is lower
   logic [FW-1:0] rt_i_ff, pu_i_ff, rt_fill_ff;
   logic          rt_done_ff, pu_done_ff, rej_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic signed [MED_W-1:0] med_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic signed [SAMPLE_WIDTH-1:0] sv;
   assign sv = sample[SAMPLE_WIDTH-1:0];

   logic [TW-1:0] total;
   assign total = TW'(lo_fill_ff) + TW'(up_fill_ff);

   assign sts.full    = (total >= TW'(CAPACITY));
   assign sts.need_rt = odd_ff ? (up_fill_ff != '0 && v_ff > up_top_ff)
                               : (lo_fill_ff != '0 && v_ff < lo_top_ff);
   assign sts.rt_done = rt_done_ff;
   assign sts.pu_done = pu_done_ff;

   // sift-down child indices
   logic [FW:0] l_idx, r_idx;
   assign l_idx = {rt_i_ff, 1'b1};
   assign r_idx = l_idx + 1'b1;
   logic [FW-1:0] pu_par;
   assign pu_par = (pu_i_ff - 1'b1) >> 1;

   // read addresses
   logic [AW-1:0] ra_a, ra_b;
   always_comb begin
      if (cmd.rt_read) begin
         ra_a = AW'(l_idx);
         ra_b = AW'(r_idx);
      end else begin
         ra_a = AW'(pu_par);
         ra_b = AW'(pu_par);
      end
   end

   // sift-down compare
   logic l_ok, r_ok, pick_r, c_wins;
   logic signed [SAMPLE_WIDTH-1:0] c_val;
   logic [FW-1:0] c_idx;
   assign l_ok   = (l_idx < {1'b0, rt_fill_ff});
   assign r_ok   = (r_idx < {1'b0, rt_fill_ff});
   assign pick_r = r_ok && (rt_max_ff ? (rd_b_ff > rd_a_ff) : (rd_b_ff < rd_a_ff));
   assign c_val  = pick_r ? rd_b_ff : rd_a_ff;
   assign c_idx  = pick_r ? FW'(r_idx) : FW'(l_idx);
   assign c_wins = l_ok && (rt_max_ff ? (c_val > v_ff) : (c_val < v_ff));

   // sift-up compare; the root has no parent and always stops
   logic p_wins;
   assign p_wins = (pu_i_ff != '0) &&
                   (pu_max_ff ? (push_ff > rd_a_ff) : (push_ff < rd_a_ff));

   // value pushed: old top after replace, else the sample
   logic signed [SAMPLE_WIDTH-1:0] push_sel;
   assign push_sel = (cmd.decide && !sts.need_rt) ? v_ff : push_ff;

   // memory write port selection
   logic          we;
   logic          we_lo;
   logic [AW-1:0] wa;
   logic signed [SAMPLE_WIDTH-1:0] wd;
   logic          pu_heap_max;
   logic [FW-1:0] pu_fill;
   assign pu_heap_max = odd_ff;  // becoming even: push to lower
   assign pu_fill     = pu_heap_max ? lo_fill_ff : up_fill_ff;

   always_comb begin
      we = 1'b0; we_lo = 1'b0; wa = '0; wd = v_ff;
      if (cmd.rt_start) begin
         we = 1'b1; we_lo = !odd_ff; wa = '0; wd = v_ff;
      end else if (cmd.rt_step) begin
         we = 1'b1; we_lo = rt_max_ff; wa = AW'(rt_i_ff);
         wd = c_wins ? c_val : v_ff;
      end else if (cmd.pu_start) begin
         we = 1'b1; we_lo = pu_heap_max; wa = AW'(pu_fill);
         wd = push_sel;
      end else if (cmd.pu_step) begin
         we = 1'b1; we_lo = pu_max_ff; wa = AW'(pu_i_ff);
         wd = p_wins ? rd_a_ff : push_ff;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (we && we_lo) lo_mem[wa] <= wd;
      if (we && !we_lo) up_mem[wa] <= wd;
   end

   // read data, held until the compare step
   always_ff @(posedge clock) begin
      if (cmd.rt_read) begin
         if (rt_max_ff) begin
            rd_a_ff <= lo_mem[ra_a];
            rd_b_ff <= lo_mem[ra_b];
         end else begin
            rd_a_ff <= up_mem[ra_a];
            rd_b_ff <= up_mem[ra_b];
         end
      end else if (cmd.pu_read) begin
         if (pu_max_ff) begin
            rd_a_ff <= lo_mem[ra_a];
         end else begin
            rd_a_ff <= up_mem[ra_a];
         end
      end
   end

   // control and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_fill_ff <= '0;
         up_fill_ff <= '0;
         odd_ff     <= 1'b0;
         rt_done_ff <= 1'b1;
         pu_done_ff <= 1'b1;
      end else begin
         if (cmd.rt_start) begin
            rt_done_ff <= 1'b0;
         end else if (cmd.rt_step) begin
            rt_done_ff <= !c_wins;
         end
         if (cmd.pu_start) begin
            pu_done_ff <= (pu_fill == '0);
            if (pu_heap_max) lo_fill_ff <= lo_fill_ff + 1'b1;
            else up_fill_ff <= up_fill_ff + 1'b1;
            odd_ff <= !odd_ff;
         end else if (cmd.pu_step) begin
            pu_done_ff <= !p_wins;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff <= sv;
      end
      if (cmd.decide) begin
         rej_ff     <= sts.full;
         rt_max_ff  <= !odd_ff;
         pu_max_ff  <= odd_ff;
         rt_i_ff    <= '0;
         pu_i_ff    <= pu_fill;
         rt_fill_ff <= odd_ff ? up_fill_ff : lo_fill_ff;
         push_ff    <= sts.need_rt ? (odd_ff ? up_top_ff : lo_top_ff) : v_ff;
      end
      if (cmd.rt_step && c_wins) begin
         rt_i_ff <= c_idx;
      end
      if (cmd.pu_step && p_wins) begin
         pu_i_ff <= pu_par;
      end
      // mirror writes at index 0 into the top registers
      if (we && wa == '0) begin
         if (we_lo) lo_top_ff <= wd;
         else up_top_ff <= wd;
      end
      if (cmd.finish) begin
         cnt_ff <= CNT_W'(total);
         if (odd_ff) begin
            med_ff <= MED_W'(up_top_ff) <<< 1;
         end else if (lo_fill_ff != '0) begin
            med_ff <= MED_W'(lo_top_ff) + MED_W'(up_top_ff);
         end else begin
            med_ff <= '0;
         end
      end
   end

   assign median_doubled = med_ff;
   assign stored_count   = cnt_ff;
   assign rejected       = rej_ff;

endmodule

FILE: hdl/running_median_two_heaps.sv
// Flow: after accept, a word passes decide, an optional sift-down, a sift-up and result
// forming; a rejected word skips both sifts. Each sift takes at most log2(CAPACITY/2)+1
// compare steps. One word in flight; the next word is accepted only after the result leaves.
// Reset: synchronous, clears fill counts and parity; heap memories keep
// contents; only entries below the fill counts are used.
// ----------------------------------------------------------------------------
// running_median_two_heaps: streaming running median over two heaps
// Returns twice the median after every accepted sample.
// ----------------------------------------------------------------------------
module running_median_two_heaps
   import rmth_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [32:0] median_doubled, [43:33] stored_count,
                                    // [44] rejected, [47:45] zero
);

   cmd_type cmd;
   sts_type sts;
   logic signed [MED_W-1:0] med;
   logic [CNT_W-1:0]        cnt;
   logic                    rej;

   rmth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rmth_datapath #(
      .CAPACITY     (CAPACITY),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .sample         (req_tdata),
      .cmd            (cmd),
      .sts            (sts),
      .median_doubled (med),
      .stored_count   (cnt),
      .rejected       (rej)
   );

   assign rsp_tdata = {3'b000, rej, cnt, med};

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: running median over two heaps, self-checking bench
// Streams signed samples into the block and checks every returned word
// against a sorted-list median predictor. Covers the extremes, ties, the
// store-full rejection path, random idling on both sides and a long stall.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rmth_pkg::*;

   localparam int CAP = CAPACITY_DEF;

   // median predictor and store of expected words
   class median_board;
      int signed held[$];
      logic [47:0] pending[$];
      int errors;
      int words;
      int rejects;

      function void note_sample(logic [31:0] s);
         int signed v;
         int pos;
         logic signed [32:0] m2;
         logic rej;
         v = s;
         rej = (held.size() >= CAP);
         if (!rej) begin
            pos = 0;
            while (pos < held.size() && held[pos] < v) pos++;
            held.insert(pos, v);
         end
         if (held.size() % 2 == 1)
            m2 = 33'(held[held.size() / 2]) <<< 1;
         else
            m2 = 33'(held[held.size() / 2 - 1]) + 33'(held[held.size() / 2]);
         pending.push_back({3'b000, rej, CNT_W'(held.size()), m2});
      endfunction

      function void check_word(logic [47:0] w);
         logic [47:0] e;
         words++;
         if (pending.size() == 0) begin
            $error("unexpected word %h", w);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e[44]) rejects++;
         if (w[32:0] !== e[32:0]) begin
            $error("median_doubled: expected %h, actual %h", e[32:0], w[32:0]);
            errors++;
         end
         if (w[43:33] !== e[43:33]) begin
            $error("stored_count: expected %0d, actual %0d", e[43:33], w[43:33]);
            errors++;
         end
         if (w[44] !== e[44]) begin
            $error("rejected: expected %b, actual %b", e[44], w[44]);
            errors++;
         end
         if (w[47:45] !== 3'b000) begin
            $error("pad: expected 0, actual %b", w[47:45]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;

   median_board board = new();
   bit quiet = 0;       // no idling in the last part
   bit hold_rsp = 0;    // long receiver stall request
   int idle_cnt = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   running_median_two_heaps dut (.*);

   // receiver: random stall bursts, plus one long hold-off
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // check accepted words
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 20000) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_sample(logic [31:0] s);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(s);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 20)) - 32'd10;
         3: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int stored_max;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, ties, sign boundaries
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h0000_0001);
      send_sample(32'h0000_0001);
      send_sample(32'h0000_0001);
      send_sample(32'h5555_5555);
      send_sample(32'hAAAA_AAAA);
      send_sample(32'h7FFF_FFFE);
      send_sample(32'h8000_0001);
      drain();

      // random fill up to full, with one long receiver stall early on
      for (int n = 0; n < 1100; n++) begin
         if (n == 100) hold_rsp = 1;
         send_sample(pick_sample());
      end

      // store full: every further sample is dropped; last part without idling
      quiet = 1;
      for (int n = 0; n < 150; n++) send_sample(pick_sample());
      drain();

      stored_max = board.held.size();
      $display("covered %0d words, %0d rejected, store peaked at %0d samples",
               board.words, board.rejects, stored_max);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
